// ===== rtl/core/npm3d_pkg.sv =====
// Shared types and constants for the 3D nearest point match block.
`timescale 1ns / 1ps

package npm3d_pkg;

  // Field widths
  localparam int COORD_W = 24;
  localparam int DIST_W  = 50;
  localparam int INDEX_W = 10;
  localparam int OP_W    = 2;
  localparam int POINT_W = 3 * COORD_W;

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // append input point to the store
    logic clear;   // empty the store
    logic start;   // latch query, reset best match and read address
    logic issue;   // read the next stored point into the pipeline
    logic finish;  // write the result word into the output register
  } npm3d_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic count_zero;  // store is empty
    logic issue_last;  // current read address is the last stored point
    logic pipe_empty;  // no point in flight in the distance pipeline
    logic out_free;    // output register can take a new word this cycle
  } npm3d_status_t;

endpackage

// ===== rtl/core/npm3d_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module npm3d_ram #(
  parameter int WIDTH  = 72,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/npm3d_ctrl.sv =====
// Controller state machine for the 3D nearest point match block.
`timescale 1ns / 1ps

module npm3d_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [npm3d_pkg::OP_W-1:0]    op,
  input  npm3d_pkg::npm3d_status_t      status,
  output npm3d_pkg::npm3d_cmd_t         cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } state_t;

  state_t state;
  state_t state_next;

  // Decode input words and sequence the store walk
  always_comb begin
    cmd        = '0;
    state_next = state;
    in_stall   = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (op)
            npm3d_pkg::OP_LOAD: begin
              cmd.load = 1'b1;
            end
            npm3d_pkg::OP_CLEAR: begin
              cmd.clear = 1'b1;
            end
            npm3d_pkg::OP_QUERY: begin
              cmd.start  = 1'b1;
              state_next = status.count_zero ? ST_DONE : ST_WALK;
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        cmd.issue = 1'b1;
        if (status.issue_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (status.pipe_empty) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/core/npm3d_dp.sv =====
// Datapath: point store, distance pipeline, best match tracking, output register.
`timescale 1ns / 1ps

module npm3d_dp #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  npm3d_pkg::npm3d_cmd_t                cmd,
  output npm3d_pkg::npm3d_status_t             status,
  input  logic                                 cfg_wr_en,
  input  logic [npm3d_pkg::DIST_W-1:0]         cfg_wr_data,
  input  logic signed [npm3d_pkg::COORD_W-1:0] coord_x,
  input  logic signed [npm3d_pkg::COORD_W-1:0] coord_y,
  input  logic signed [npm3d_pkg::COORD_W-1:0] coord_z,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 found,
  output logic [npm3d_pkg::INDEX_W-1:0]        nearest_index,
  output logic signed [npm3d_pkg::COORD_W-1:0] match_x,
  output logic signed [npm3d_pkg::COORD_W-1:0] match_y,
  output logic signed [npm3d_pkg::COORD_W-1:0] match_z,
  output logic [npm3d_pkg::DIST_W-1:0]         distance_sq
);

  localparam int CW   = npm3d_pkg::COORD_W;
  localparam int DW   = npm3d_pkg::DIST_W;
  localparam int PW   = npm3d_pkg::POINT_W;
  localparam int IXW  = npm3d_pkg::INDEX_W;
  localparam int IW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int NW   = $clog2(MAX_POINTS + 1);
  localparam int SQW  = 2 * CW;
  localparam int DIFW = CW + 1;

  // Configuration and store bookkeeping
  logic [DW-1:0] max_distance_sq;
  logic [NW-1:0] point_count;
  logic          store_full;
  logic [IW-1:0] rd_addr;

  // Query point
  logic signed [CW-1:0] qx, qy, qz;

  // Pipeline: read data, differences, squares, sum
  logic          v1, v2, v3, v4;
  logic [IW-1:0] idx1, idx2, idx3, idx4;
  logic [PW-1:0] ram_rd_data;
  logic [PW-1:0] pt2, pt3, pt4;
  logic signed [DIFW-1:0] dif_x, dif_y, dif_z;
  logic signed [2*DIFW-1:0] prod_x, prod_y, prod_z;
  logic [SQW-1:0] sq_x, sq_y, sq_z;
  logic [DW-1:0]  dist4;

  // Best match
  logic          best_valid;
  logic [DW-1:0] best_d;
  logic [IW-1:0] best_idx;
  logic [PW-1:0] best_pt;
  logic          take_new;

  // Result formatting
  logic                 res_found;
  logic [IW+IXW-1:0]    best_idx_wide;

  assign store_full = (point_count == NW'(MAX_POINTS));

  npm3d_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.load && !store_full),
    .wr_addr (point_count[IW-1:0]),
    .wr_data ({coord_x, coord_y, coord_z}),
    .rd_en   (cmd.issue),
    .rd_addr (rd_addr),
    .rd_data (ram_rd_data)
  );

  // Status back to the controller
  assign status.count_zero = (point_count == '0);
  assign status.issue_last = ((NW'(rd_addr) + NW'(1)) == point_count);
  assign status.pipe_empty = !(v1 || v2 || v3 || v4);
  assign status.out_free   = !out_valid || !out_stall;

  // Hold the distance limit
  always_ff @(posedge clk) begin
    if (rst) begin
      max_distance_sq <= '1;
    end else if (cfg_wr_en) begin
      max_distance_sq <= cfg_wr_data;
    end
  end

  // Track the point count; drop loads into a full store
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
    end else if (cmd.clear) begin
      point_count <= '0;
    end else if (cmd.load && !store_full) begin
      point_count <= point_count + NW'(1);
    end
  end

  // Latch the query and advance the read address
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      qx      <= coord_x;
      qy      <= coord_y;
      qz      <= coord_z;
      rd_addr <= '0;
    end else if (cmd.issue) begin
      rd_addr <= rd_addr + IW'(1);
    end
  end

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Differences against the stored point
  always_comb begin
    dif_x = {qx[CW-1], qx} - {ram_rd_data[PW-1], ram_rd_data[PW-1 -: CW]};
    dif_y = {qy[CW-1], qy} - {ram_rd_data[2*CW-1], ram_rd_data[2*CW-1 -: CW]};
    dif_z = {qz[CW-1], qz} - {ram_rd_data[CW-1], ram_rd_data[CW-1:0]};
  end

  // Products of the registered differences
  logic signed [DIFW-1:0] d2_x, d2_y, d2_z;

  always_comb begin
    prod_x = d2_x * d2_x;
    prod_y = d2_y * d2_y;
    prod_z = d2_z * d2_z;
  end

  // Advance index, point and partial results through the stages
  always_ff @(posedge clk) begin
    idx1  <= rd_addr;
    idx2  <= idx1;
    pt2   <= ram_rd_data;
    d2_x  <= dif_x;
    d2_y  <= dif_y;
    d2_z  <= dif_z;
    idx3  <= idx2;
    pt3   <= pt2;
    sq_x  <= prod_x[SQW-1:0];
    sq_y  <= prod_y[SQW-1:0];
    sq_z  <= prod_z[SQW-1:0];
    idx4  <= idx3;
    pt4   <= pt3;
    dist4 <= DW'(sq_x) + DW'(sq_y) + DW'(sq_z);
  end

  // Keep the earliest point at the smallest distance
  assign take_new = v4 && (!best_valid || (dist4 < best_d));

  always_ff @(posedge clk) begin
    if (rst) begin
      best_valid <= 1'b0;
    end else if (cmd.start) begin
      best_valid <= 1'b0;
    end else if (v4) begin
      best_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      best_d   <= '0;
      best_idx <= '0;
    end else if (take_new) begin
      best_d   <= dist4;
      best_idx <= idx4;
      best_pt  <= pt4;
    end
  end

  // Format the result word
  assign res_found     = best_valid && (best_d <= max_distance_sq);
  assign best_idx_wide = {{IXW{1'b0}}, best_idx};

  // Output register: load on finish, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      found         <= res_found;
      nearest_index <= best_idx_wide[IXW-1:0];
      distance_sq   <= best_d;
      if (res_found) begin
        match_x <= best_pt[PW-1 -: CW];
        match_y <= best_pt[2*CW-1 -: CW];
        match_z <= best_pt[CW-1:0];
      end else begin
        match_x <= qx;
        match_y <= qy;
        match_z <= qz;
      end
    end
  end

endmodule

// ===== rtl/core/nearest_point_match_3d_top.sv =====
// Top level of the 3D nearest point match block.
//
//   channel  direction  handshake            payload
//   input    in         in_valid / in_stall  op, coord_x, coord_y, coord_z
//   result   out        out_valid/out_stall  found, nearest_index, match_x/y/z,
//                                            distance_sq
//   config   in         cfg_wr_en            cfg_wr_data (max_distance_sq)
//
// Load, clear and unused ops leave the controller idle. A query walks the point
// store one entry per cycle through the single read port, then drains the
// distance pipeline and writes the result. Reset empties the store and sets
// the limit to all ones. The input stalls while a query runs; a finished
// result waits in the output register until taken, and a later query waits
// for it before its own write.
`timescale 1ns / 1ps

module nearest_point_match_3d_top #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [npm3d_pkg::OP_W-1:0]           op,
  input  logic signed [npm3d_pkg::COORD_W-1:0] coord_x,
  input  logic signed [npm3d_pkg::COORD_W-1:0] coord_y,
  input  logic signed [npm3d_pkg::COORD_W-1:0] coord_z,
  input  logic                                 cfg_wr_en,
  input  logic [npm3d_pkg::DIST_W-1:0]         cfg_wr_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 found,
  output logic [npm3d_pkg::INDEX_W-1:0]        nearest_index,
  output logic signed [npm3d_pkg::COORD_W-1:0] match_x,
  output logic signed [npm3d_pkg::COORD_W-1:0] match_y,
  output logic signed [npm3d_pkg::COORD_W-1:0] match_z,
  output logic [npm3d_pkg::DIST_W-1:0]         distance_sq
);

  npm3d_pkg::npm3d_cmd_t    cmd;
  npm3d_pkg::npm3d_status_t status;

  // Sequence the ops
  npm3d_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .op       (op),
    .status   (status),
    .cmd      (cmd)
  );

  // Store, distance pipeline and result register
  npm3d_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .coord_x       (coord_x),
    .coord_y       (coord_y),
    .coord_z       (coord_z),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .found         (found),
    .nearest_index (nearest_index),
    .match_x       (match_x),
    .match_y       (match_y),
    .match_z       (match_z),
    .distance_sq   (distance_sq)
  );

endmodule

// ===== bench/nearest_point_match_3d_top_tb.sv =====
// Self-checking testbench for the 3D nearest point match block.
`timescale 1ns / 1ps

module nearest_point_match_3d_top_tb;

  localparam int OP_W    = npm3d_pkg::OP_W;
  localparam int COORD_W = npm3d_pkg::COORD_W;
  localparam int DIST_W  = npm3d_pkg::DIST_W;
  localparam int INDEX_W = npm3d_pkg::INDEX_W;
  localparam logic [OP_W-1:0] OP_LOAD  = npm3d_pkg::OP_LOAD;
  localparam logic [OP_W-1:0] OP_QUERY = npm3d_pkg::OP_QUERY;
  localparam logic [OP_W-1:0] OP_CLEAR = npm3d_pkg::OP_CLEAR;

  localparam int STORE_DEPTH  = 1024;
  localparam int QUERY_SETTLE = STORE_DEPTH + 16;
  localparam int CYCLE_LIMIT  = 4000000;
  localparam int PHASE_WORDS  = 64;
  localparam int FILL_POINTS  = 160;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam logic [DIST_W-1:0] LIMIT_ALL_ONES = '1;
  localparam logic [DIST_W-1:0] LIMIT_HALF = {1'b1, {(DIST_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] index;
    coord_t             x;
    coord_t             y;
    coord_t             z;
    logic [DIST_W-1:0]  dist_val;
  } match_t;

  typedef enum {ROW_WORD, ROW_LIMIT} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [OP_W-1:0]   opcode;
    coord_t            x;
    coord_t            y;
    coord_t            z;
    bit                typed;
    match_t            want;
    logic [DIST_W-1:0] limit;
  } row_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [OP_W-1:0] op;
  coord_t coord_x, coord_y, coord_z;
  logic cfg_wr_en;
  logic [DIST_W-1:0] cfg_wr_data;
  logic out_valid;
  logic out_stall = 1'b0;
  logic found;
  logic [INDEX_W-1:0] nearest_index;
  coord_t match_x, match_y, match_z;
  logic [DIST_W-1:0] distance_sq;

  // Shadow copy of the point store and the limit register
  coord_t ref_pts_x [STORE_DEPTH];
  coord_t ref_pts_y [STORE_DEPTH];
  coord_t ref_pts_z [STORE_DEPTH];
  int stored_points = 0;
  logic [DIST_W-1:0] match_limit_sq = LIMIT_ALL_ONES;

  match_t pending_matches [$];
  row_t directed_rows [$];
  int mismatches = 0;
  bit steady_flow = 1'b0;

  always #4 clk = ~clk;

  nearest_point_match_3d_top #(
    .MAX_POINTS(STORE_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .coord_x(coord_x),
    .coord_y(coord_y),
    .coord_z(coord_z),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .found(found),
    .nearest_index(nearest_index),
    .match_x(match_x),
    .match_y(match_y),
    .match_z(match_z),
    .distance_sq(distance_sq)
  );

  // Exact squared Euclidean distance between two points
  function automatic logic [DIST_W-1:0] dist_sq(input coord_t ax, ay, az, bx, by, bz);
    longint dx, dy, dz, sum;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    dz = longint'(az) - longint'(bz);
    sum = dx * dx + dy * dy + dz * dz;
    return sum[DIST_W-1:0];
  endfunction

  // Scan the shadow store; the earliest point wins a tie
  function automatic match_t nearest_match_of(input coord_t qx, qy, qz);
    match_t m;
    logic [DIST_W-1:0] d;
    m = '0;
    for (int i = 0; i < stored_points; i++) begin
      d = dist_sq(qx, qy, qz, ref_pts_x[i], ref_pts_y[i], ref_pts_z[i]);
      if (i == 0 || d < m.dist_val) begin
        m.dist_val = d;
        m.index = i[INDEX_W-1:0];
      end
    end
    m.found = (stored_points > 0) && (m.dist_val <= match_limit_sq);
    if (m.found) begin
      m.x = ref_pts_x[m.index];
      m.y = ref_pts_y[m.index];
      m.z = ref_pts_z[m.index];
    end else begin
      m.x = qx;
      m.y = qy;
      m.z = qz;
    end
    return m;
  endfunction

  // Advance the shadow state for one accepted word
  function automatic void record_word(input logic [OP_W-1:0] o, input coord_t x, y, z,
                                      input bit typed, input match_t want);
    case (o)
      OP_LOAD: begin
        if (stored_points < STORE_DEPTH) begin
          ref_pts_x[stored_points] = x;
          ref_pts_y[stored_points] = y;
          ref_pts_z[stored_points] = z;
          stored_points++;
        end
      end
      OP_CLEAR: begin
        stored_points = 0;
      end
      OP_QUERY: begin
        pending_matches.push_back(typed ? want : nearest_match_of(x, y, z));
      end
      default: ;
    endcase
  endfunction

  // Present one word, with random gaps ahead of it, and hold it until taken
  task automatic send_word(input logic [OP_W-1:0] o, input coord_t x, y, z,
                           input bit typed, input match_t want);
    if (!steady_flow) begin
      while ($urandom_range(99) < 30) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    op <= o;
    coord_x <= x;
    coord_y <= y;
    coord_z <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    record_word(o, x, y, z, typed, want);
  endtask

  // Hold the sender until every outstanding result is in, optionally let a
  // full-store query drain past that
  task automatic wait_results_done(input bit settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_matches.size() != 0) @(posedge clk);
    if (settle) repeat (QUERY_SETTLE) @(posedge clk);
  endtask

  task automatic write_limit(input logic [DIST_W-1:0] v);
    wait_results_done(1'b1);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    match_limit_sq = v;
  endtask

  function automatic void add_word(input logic [OP_W-1:0] o, input coord_t x, y, z);
    row_t r;
    r = '{ROW_WORD, o, x, y, z, 1'b0, '0, '0};
    directed_rows.push_back(r);
  endfunction

  function automatic void add_query(input coord_t x, y, z, input logic f, input int idx,
                                    input coord_t mx, my, mz, input logic [DIST_W-1:0] d);
    row_t r;
    r = '{ROW_WORD, OP_QUERY, x, y, z, 1'b1, '0, '0};
    r.want.found = f;
    r.want.index = idx[INDEX_W-1:0];
    r.want.x = mx;
    r.want.y = my;
    r.want.z = mz;
    r.want.dist_val = d;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_limit(input logic [DIST_W-1:0] v);
    row_t r;
    r = '{ROW_LIMIT, OP_LOAD, '0, '0, '0, 1'b0, '0, v};
    directed_rows.push_back(r);
  endfunction

  // Mostly small values, some full-range, some at the extremes
  function automatic coord_t any_coord();
    int r;
    int v;
    logic [31:0] raw;
    r = $urandom_range(99);
    raw = $urandom;
    v = int'($urandom_range(4000)) - 2000;
    if (r < 5) return C_MIN;
    if (r < 10) return C_MAX;
    if (r < 40) return raw[COORD_W-1:0];
    return v[COORD_W-1:0];
  endfunction

  function automatic coord_t near_coord(input coord_t base, input bit exact);
    int s;
    s = int'(base);
    if (!exact) s = s + int'($urandom_range(80)) - 40;
    return s[COORD_W-1:0];
  endfunction

  // Mostly loads and queries around stored points; some noise
  function automatic void random_word(output logic [OP_W-1:0] o, output coord_t x, y, z);
    int r;
    int pick;
    bit exact;
    r = $urandom_range(99);
    exact = ($urandom_range(3) == 0);
    if (r < 3) begin
      o = OP_SPARE;
    end else if (r < 8 || (stored_points > 40 && r < 35)) begin
      o = OP_CLEAR;
    end else begin
      o = (r < 52) ? OP_LOAD : OP_QUERY;
    end
    if (stored_points > 0 && $urandom_range(99) < 70) begin
      pick = $urandom_range(stored_points - 1);
      x = near_coord(ref_pts_x[pick], exact);
      y = near_coord(ref_pts_y[pick], exact);
      z = near_coord(ref_pts_z[pick], exact);
    end else begin
      x = any_coord();
      y = any_coord();
      z = any_coord();
    end
  endfunction

  // Spread points so a long run holds no duplicates
  function automatic void grid_point(input int i, output coord_t x, y, z);
    int vx, vy, vz;
    vx = i * 8191 - 4000000;
    vy = 3000 - i * 5;
    vz = (i % 37) * 100 - 1800;
    x = vx[COORD_W-1:0];
    y = vy[COORD_W-1:0];
    z = vz[COORD_W-1:0];
  endfunction

  task automatic check_field(input string name, input logic signed [63:0] want_v, got_v);
    if (got_v !== want_v) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want_v, got_v);
    end
  endtask

  // Take result words, compare against the oldest expectation, stall at random
  always @(posedge clk) begin
    match_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_matches.size() == 0) begin
        mismatches++;
        $display("%0t: result word with none expected, actual index %0d dist %0d",
                 $time, nearest_index, distance_sq);
      end else begin
        want = pending_matches.pop_front();
        check_field("found", want.found, found);
        check_field("nearest_index", want.index, nearest_index);
        check_field("match_x", want.x, match_x);
        check_field("match_y", want.y, match_y);
        check_field("match_z", want.z, match_z);
        check_field("distance_sq", want.dist_val, distance_sq);
      end
    end
    out_stall <= !steady_flow && ($urandom_range(99) < 30);
  end

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAIL nearest_point_match_3d_top");
    $finish;
  end

  initial begin
    logic [OP_W-1:0] o;
    coord_t x, y, z;
    logic [DIST_W-1:0] phase_limit;
    logic [63:0] wide;

    rst <= 1'b1;
    in_valid <= 1'b0;
    op <= OP_LOAD;
    coord_x <= '0;
    coord_y <= '0;
    coord_z <= '0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;

    // Directed rows: empty store, ignored op, extremes, ties, limit edges, clear
    add_query(C_MIN, C_MAX, 0, 1'b0, 0, C_MIN, C_MAX, 0, '0);
    add_word(OP_SPARE, 1193046, -1, 7);
    add_query(5, 6, 7, 1'b0, 0, 5, 6, 7, '0);
    add_word(OP_LOAD, C_MIN, C_MIN, C_MIN);
    add_query(C_MAX, C_MAX, C_MAX, 1'b1, 0, C_MIN, C_MIN, C_MIN, 50'd844424829468675);
    add_word(OP_LOAD, C_MAX, C_MAX, C_MAX);
    add_query(C_MAX, C_MAX, C_MAX, 1'b1, 1, C_MAX, C_MAX, C_MAX, '0);
    add_word(OP_LOAD, 100, -200, 300);
    add_word(OP_LOAD, 100, -200, 300);
    add_word(OP_QUERY, 100, -200, 300);
    add_word(OP_LOAD, 3, 5000, 4);
    add_word(OP_LOAD, -4, 5000, -3);
    add_word(OP_QUERY, 0, 5000, 0);
    add_word(OP_QUERY, -77, 12345, -999);
    add_limit(50'd25);
    add_word(OP_QUERY, 0, 5000, 0);
    add_word(OP_QUERY, 0, 5001, 0);
    add_limit('0);
    add_word(OP_QUERY, 100, -200, 300);
    add_word(OP_QUERY, 100, -200, 301);
    add_word(OP_CLEAR, C_MAX, 0, C_MIN);
    add_query(1, -2, 3, 1'b0, 0, 1, -2, 3, '0);
    add_word(OP_LOAD, 0, 0, 0);
    add_word(OP_QUERY, 0, 0, 0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed rows
    foreach (directed_rows[k]) begin
      if (directed_rows[k].kind == ROW_LIMIT)
        write_limit(directed_rows[k].limit);
      else
        send_word(directed_rows[k].opcode, directed_rows[k].x, directed_rows[k].y,
                  directed_rows[k].z, directed_rows[k].typed, directed_rows[k].want);
    end

    // Random phases, one limit setting each
    for (int p = 0; p < 6; p++) begin
      wide = {$urandom, $urandom};
      case (p)
        0: phase_limit = LIMIT_ALL_ONES;
        1: phase_limit = '0;
        2: phase_limit = {{(DIST_W-32){1'b0}}, $urandom_range(3000)};
        3: phase_limit = wide[DIST_W-1:0];
        4: phase_limit = {{(DIST_W-32){1'b0}}, $urandom_range(6000)};
        default: phase_limit = LIMIT_HALF;
      endcase
      write_limit(phase_limit);
      steady_flow = (p == 2);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // pause the sender until the results catch up
        if (n == 40 || $urandom_range(99) == 0) wait_results_done(1'b0);
        random_word(o, x, y, z);
        send_word(o, x, y, z, 1'b0, '0);
      end
      steady_flow = 1'b0;
    end

    // Load a long run of points and query across it
    wide = {32'd0, $urandom_range(5000)};
    write_limit(wide[DIST_W-1:0]);
    send_word(OP_CLEAR, 0, 0, 0, 1'b0, '0);
    for (int i = 0; i < FILL_POINTS; i++) begin
      grid_point(i, x, y, z);
      send_word(OP_LOAD, x, y, z, 1'b0, '0);
    end
    send_word(OP_QUERY, ref_pts_x[FILL_POINTS-1], ref_pts_y[FILL_POINTS-1],
              ref_pts_z[FILL_POINTS-1], 1'b0, '0);
    send_word(OP_QUERY, ref_pts_x[FILL_POINTS/2], ref_pts_y[FILL_POINTS/2],
              ref_pts_z[FILL_POINTS/2], 1'b0, '0);
    grid_point(FILL_POINTS + 1, x, y, z);
    send_word(OP_QUERY, x, y, z, 1'b0, '0);
    send_word(OP_QUERY, near_coord(ref_pts_x[100], 1'b0), near_coord(ref_pts_y[100], 1'b0),
              near_coord(ref_pts_z[100], 1'b0), 1'b0, '0);
    send_word(OP_QUERY, any_coord(), any_coord(), any_coord(), 1'b0, '0);

    wait_results_done(1'b1);
    if (mismatches == 0 && pending_matches.size() == 0) begin
      $display("PASS nearest_point_match_3d_top");
    end else begin
      $display("FAIL nearest_point_match_3d_top");
    end
    $finish;
  end

endmodule
